// ===== design/acfp_pkg.sv =====
// shared constants and control/status types for the ascii command frame parser
package acfp_pkg;

    // default frame limits
    localparam int CMD_MAX_DEF    = 8;
    localparam int LEN_DIGITS_DEF = 3;
    localparam int DATA_MAX_DEF   = 32;
    localparam int CRC_MAX_DEF    = 4;

    // fixed result field widths
    localparam int CLASS_W      = 2;
    localparam int LENGTH_W     = 10;
    localparam int CRC_TEXT_W   = 32;
    localparam int CRC_CHARS_W  = 3;
    localparam int DATA_COUNT_W = 5;
    localparam int CRC_SLOTS    = 4;
    localparam int CMD_SLOTS    = 4;

    // framing characters
    localparam logic [7:0] CHAR_START = 8'h24;  // '$'
    localparam logic [7:0] CHAR_SEP   = 8'h2C;  // ','
    localparam logic [7:0] CHAR_END   = 8'h40;  // '@'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_W     = 8'h57;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_D     = 8'h44;

    // length saturation and decimal base
    localparam logic [LENGTH_W-1:0] LEN_SAT = 10'd1023;
    localparam int                  RADIX   = 10;

    // command classes
    localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WRITE = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_READ  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic take;       // input word accepted this cycle
        logic run_clear;  // restart result run at first data byte
        logic run_step;   // advance to next data byte
        logic out_load;   // capture one result into output registers
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic frame_end;  // current byte closes an open frame
        logic run_last;   // current run index is the final result
    } dp_sts_t;

endpackage

// ===== design/ascii_command_frame_parser.sv =====
// top level of the ascii command frame parser
//
//  channel  | signals                          | direction | word
//  ---------+----------------------------------+-----------+------------------------
//  rx       | rx_valid rx_ready rx_byte        | in        | one received byte
//  res      | res_valid res_ready cmd_class .. | out       | one result of a frame
//
//  bytes are taken one per cycle while no result run is in progress
//  a closing '@' starts a run of max(1, data count) results, each passing
//  through a fetch and a fill state, set by the registered read of the data byte memory
//  a stalled result holds the run; the last result frees intake at once
//  reset clears frame fields; the data memory needs no clearing pass
module ascii_command_frame_parser
    import acfp_pkg::*;
#(
    parameter int CMD_MAX    = CMD_MAX_DEF,
    parameter int LEN_DIGITS = LEN_DIGITS_DEF,
    parameter int DATA_MAX   = DATA_MAX_DEF,
    parameter int CRC_MAX    = CRC_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rx_valid,
    output logic                                rx_ready,
    input  logic [7:0]                          rx_byte,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [acfp_pkg::CLASS_W-1:0]        cmd_class,
    output logic [acfp_pkg::LENGTH_W-1:0]       declared_length,
    output logic [acfp_pkg::CRC_TEXT_W-1:0]     crc_text,
    output logic [acfp_pkg::CRC_CHARS_W-1:0]    crc_chars,
    output logic [acfp_pkg::DATA_COUNT_W-1:0]   data_count,
    output logic [7:0]                          data_byte,
    output logic                                last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    acfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // parsing and storage
    acfp_datapath #(
        .CMD_MAX    (CMD_MAX),
        .LEN_DIGITS (LEN_DIGITS),
        .DATA_MAX   (DATA_MAX),
        .CRC_MAX    (CRC_MAX)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_byte         (rx_byte),
        .cmd             (cmd),
        .sts             (sts),
        .cmd_class       (cmd_class),
        .declared_length (declared_length),
        .crc_text        (crc_text),
        .crc_chars       (crc_chars),
        .data_count      (data_count),
        .data_byte       (data_byte),
        .last            (last)
    );

endmodule

// ===== design/acfp_datapath.sv =====
// field parsing, frame storage and result registers of the frame parser
module acfp_datapath #(
    parameter int CMD_MAX    = 8,
    parameter int LEN_DIGITS = 3,
    parameter int DATA_MAX   = 32,
    parameter int CRC_MAX    = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [7:0]                          rx_byte,
    input  acfp_pkg::dp_cmd_t                   cmd,
    output acfp_pkg::dp_sts_t                   sts,
    output logic [acfp_pkg::CLASS_W-1:0]        cmd_class,
    output logic [acfp_pkg::LENGTH_W-1:0]       declared_length,
    output logic [acfp_pkg::CRC_TEXT_W-1:0]     crc_text,
    output logic [acfp_pkg::CRC_CHARS_W-1:0]    crc_chars,
    output logic [acfp_pkg::DATA_COUNT_W-1:0]   data_count,
    output logic [7:0]                          data_byte,
    output logic                                last
);
    import acfp_pkg::*;

    localparam int AW      = $clog2(DATA_MAX);
    localparam int CMD_W   = $clog2(CMD_MAX);
    localparam int CNT_MAX = (CMD_MAX > DATA_MAX) ? CMD_MAX : DATA_MAX;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int PROD_W  = LENGTH_W + 4;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_CMD,
        FS_LEN,
        FS_DATA,
        FS_CRC,
        FS_TAIL
    } field_t;

    field_t                 field_reg, field_next;
    logic [CNT_W-1:0]       char_count_reg, char_count_next;
    logic [7:0]             cmd_chars_reg [CMD_SLOTS];
    logic [7:0]             cmd_chars_next [CMD_SLOTS];
    logic [CMD_W-1:0]       cmd_len_reg, cmd_len_next;
    logic [LENGTH_W-1:0]    length_reg, length_next;
    logic [AW-1:0]          data_len_reg, data_len_next;
    logic [7:0]             crc_reg [CRC_SLOTS];
    logic [7:0]             crc_next [CRC_SLOTS];
    logic [CRC_CHARS_W-1:0] crc_len_reg, crc_len_next;
    logic [AW-1:0]          run_idx_reg, run_idx_next;

    logic [7:0]             data_mem [DATA_MAX];
    logic [7:0]             rd_data_reg;
    logic                   wr_en;

    logic [PROD_W-1:0]      len_prod;
    logic [CLASS_W-1:0]     class_now;
    logic [AW:0]            run_count;

    // result registers
    logic [CLASS_W-1:0]      cmd_class_reg;
    logic [LENGTH_W-1:0]     declared_length_reg;
    logic [CRC_TEXT_W-1:0]   crc_text_reg;
    logic [CRC_CHARS_W-1:0]  crc_chars_reg;
    logic [DATA_COUNT_W-1:0] data_count_reg;
    logic [7:0]              data_byte_reg;
    logic                    last_reg;

    // decimal accumulate: value * 10 + digit
    assign len_prod = PROD_W'({length_reg, 3'b000}) + PROD_W'({length_reg, 1'b0})
                    + PROD_W'(rx_byte - CHAR_ZERO);

    // frame field update per accepted byte
    always_comb
    begin
        field_next      = field_reg;
        char_count_next = char_count_reg;
        cmd_chars_next  = cmd_chars_reg;
        cmd_len_next    = cmd_len_reg;
        length_next     = length_reg;
        data_len_next   = data_len_reg;
        crc_next        = crc_reg;
        crc_len_next    = crc_len_reg;
        wr_en           = 1'b0;
        if (cmd.take)
        begin
            if (rx_byte == CHAR_START)
            begin
                field_next      = FS_CMD;
                char_count_next = '0;
                for (int i = 0; i < CMD_SLOTS; i++)
                begin
                    cmd_chars_next[i] = '0;
                end
                cmd_len_next    = '0;
                length_next     = '0;
                data_len_next   = '0;
                for (int i = 0; i < CRC_SLOTS; i++)
                begin
                    crc_next[i] = '0;
                end
                crc_len_next    = '0;
            end
            else if (rx_byte == CHAR_SEP)
            begin
                case (field_reg)
                    FS_CMD:  begin field_next = FS_LEN;  char_count_next = '0; end
                    FS_LEN:  begin field_next = FS_DATA; char_count_next = '0; end
                    FS_DATA: begin field_next = FS_CRC;  char_count_next = '0; end
                    FS_CRC:  begin field_next = FS_TAIL; char_count_next = '0; end
                    default: ;
                endcase
            end
            else if (rx_byte == CHAR_END)
            begin
                field_next = FS_IDLE;
            end
            else
            begin
                case (field_reg)
                    FS_CMD:
                    begin
                        if (char_count_reg < CNT_W'(CMD_MAX - 1))
                        begin
                            if (char_count_reg < CNT_W'(CMD_SLOTS))
                            begin
                                cmd_chars_next[char_count_reg[1:0]] = rx_byte;
                            end
                            char_count_next = char_count_reg + 1'b1;
                            cmd_len_next    = CMD_W'(char_count_reg + 1'b1);
                        end
                    end
                    FS_LEN:
                    begin
                        if (char_count_reg < CNT_W'(LEN_DIGITS) &&
                            (rx_byte inside {[CHAR_ZERO:CHAR_NINE]}))
                        begin
                            length_next     = (len_prod > PROD_W'(LEN_SAT)) ?
                                              LEN_SAT : len_prod[LENGTH_W-1:0];
                            char_count_next = char_count_reg + 1'b1;
                        end
                    end
                    FS_DATA:
                    begin
                        if (char_count_reg < CNT_W'(DATA_MAX - 1))
                        begin
                            wr_en           = 1'b1;
                            char_count_next = char_count_reg + 1'b1;
                            data_len_next   = AW'(char_count_reg + 1'b1);
                        end
                    end
                    FS_CRC:
                    begin
                        if (char_count_reg < CNT_W'(CRC_MAX))
                        begin
                            crc_next[char_count_reg[1:0]] = rx_byte;
                            char_count_next = char_count_reg + 1'b1;
                            crc_len_next    = CRC_CHARS_W'(char_count_reg + 1'b1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // run index for the result sequence
    always_comb
    begin
        run_idx_next = run_idx_reg;
        if (cmd.run_clear)
        begin
            run_idx_next = '0;
        end
        else if (cmd.run_step)
        begin
            run_idx_next = run_idx_reg + 1'b1;
        end
    end

    // command classification on a command of exactly four stored characters
    always_comb
    begin
        class_now = CLASS_OTHER;
        if (cmd_len_reg == CMD_W'(CMD_SLOTS) && cmd_chars_reg[0] == CHAR_H &&
            cmd_chars_reg[1] == CHAR_W)
        begin
            if (cmd_chars_reg[2] == CHAR_W && cmd_chars_reg[3] == CHAR_R)
            begin
                class_now = CLASS_WRITE;
            end
            else if (cmd_chars_reg[2] == CHAR_R && cmd_chars_reg[3] == CHAR_D)
            begin
                class_now = CLASS_READ;
            end
        end
    end

    // run of at least one result
    assign run_count     = (data_len_reg == '0) ? (AW+1)'(1) : {1'b0, data_len_reg};
    assign sts.run_last  = (({1'b0, run_idx_reg} + 1'b1) == run_count);
    assign sts.frame_end = (rx_byte == CHAR_END) && (field_reg != FS_IDLE);

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg      <= FS_IDLE;
            char_count_reg <= '0;
            for (int i = 0; i < CMD_SLOTS; i++)
            begin
                cmd_chars_reg[i] <= '0;
            end
            cmd_len_reg    <= '0;
            length_reg     <= '0;
            data_len_reg   <= '0;
            for (int i = 0; i < CRC_SLOTS; i++)
            begin
                crc_reg[i] <= '0;
            end
            crc_len_reg    <= '0;
            run_idx_reg    <= '0;
        end
        else
        begin
            field_reg      <= field_next;
            char_count_reg <= char_count_next;
            cmd_chars_reg  <= cmd_chars_next;
            cmd_len_reg    <= cmd_len_next;
            length_reg     <= length_next;
            data_len_reg   <= data_len_next;
            crc_reg        <= crc_next;
            crc_len_reg    <= crc_len_next;
            run_idx_reg    <= run_idx_next;
        end
    end

    // data byte memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_mem[char_count_reg[AW-1:0]] <= rx_byte;
        end
        rd_data_reg <= data_mem[run_idx_reg];
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cmd_class_reg       <= class_now;
            declared_length_reg <= length_reg;
            crc_text_reg        <= {crc_reg[0], crc_reg[1], crc_reg[2], crc_reg[3]};
            crc_chars_reg       <= crc_len_reg;
            data_count_reg      <= DATA_COUNT_W'(data_len_reg);
            data_byte_reg       <= (data_len_reg == '0) ? 8'd0 : rd_data_reg;
            last_reg            <= sts.run_last;
        end
    end

    assign cmd_class       = cmd_class_reg;
    assign declared_length = declared_length_reg;
    assign crc_text        = crc_text_reg;
    assign crc_chars       = crc_chars_reg;
    assign data_count      = data_count_reg;
    assign data_byte       = data_byte_reg;
    assign last            = last_reg;

endmodule

// ===== design/acfp_ctrl.sv =====
// handshake and result run sequencer of the frame parser
module acfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    output logic              res_valid,
    input  logic              res_ready,
    input  acfp_pkg::dp_sts_t sts,
    output acfp_pkg::dp_cmd_t cmd
);
    import acfp_pkg::*;

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_FETCH,
        ST_FILL
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   slot_free;

    assign rx_ready  = (state_reg == ST_ACCEPT);
    assign res_valid = res_valid_reg;
    assign slot_free = !res_valid_reg || res_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        cmd            = '0;
        cmd.take       = rx_valid && rx_ready;
        case (state_reg)
            ST_ACCEPT:
            begin
                if (cmd.take && sts.frame_end)
                begin
                    cmd.run_clear = 1'b1;
                    state_next    = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    res_valid_next = 1'b1;
                    if (sts.run_last)
                    begin
                        state_next = ST_ACCEPT;
                    end
                    else
                    begin
                        cmd.run_step = 1'b1;
                        state_next   = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // no byte taken while a run is being loaded
    a_no_take_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !cmd.take)
        else $error("byte accepted during result run");

    // a loaded result is offered next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> res_valid)
        else $error("loaded result not presented");

    // end of frame stops intake
    a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && sts.frame_end) |=> !rx_ready)
        else $error("intake continued after frame end");

    // final result of a run reopens intake
    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && sts.run_last) |=> rx_ready)
        else $error("intake not reopened after final result");

endmodule

// ===== dv/tb_ascii_command_frame_parser.sv =====
// testbench for the ascii command frame parser with a built-in frame predictor
`timescale 1ns / 100ps

module tb_ascii_command_frame_parser;
    import acfp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 40;

    // parser field states tracked by the predictor
    typedef enum logic [2:0] {
        PS_IDLE,
        PS_CMD,
        PS_LEN,
        PS_DATA,
        PS_CRC,
        PS_TAIL
    } parse_state_t;

    // one result word of a finished frame
    typedef struct {
        logic [CLASS_W-1:0]      cls;
        logic [LENGTH_W-1:0]     len;
        logic [CRC_TEXT_W-1:0]   crc;
        logic [CRC_CHARS_W-1:0]  crc_n;
        logic [DATA_COUNT_W-1:0] dcount;
        logic [7:0]              dbyte;
        logic                    fin;
    } frame_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    rx_valid = 1'b0;
    logic                    rx_ready;
    logic [7:0]              rx_byte = 8'h00;
    logic                    res_valid;
    logic                    res_ready = 1'b0;
    logic [CLASS_W-1:0]      cmd_class;
    logic [LENGTH_W-1:0]     declared_length;
    logic [CRC_TEXT_W-1:0]   crc_text;
    logic [CRC_CHARS_W-1:0]  crc_chars;
    logic [DATA_COUNT_W-1:0] data_count;
    logic [7:0]              data_byte;
    logic                    last;

    // predictor copy of the frame fields
    parse_state_t        pstate = PS_IDLE;
    int                  field_cnt;
    logic [7:0]          cmd_buf [CMD_MAX_DEF];
    int                  cmd_len;
    logic [LENGTH_W-1:0] len_val;
    logic [7:0]          data_buf [DATA_MAX_DEF];
    int                  data_len;
    logic [7:0]          crc_buf [CRC_SLOTS];
    int                  crc_len;

    frame_result_t frame_results_due[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int errors = 0;
    int cycles = 0;
    int bytes_used = 0;
    int results_due = 0;
    int results_seen = 0;
    int frames_closed = 0;

    ascii_command_frame_parser #(
        .CMD_MAX    (CMD_MAX_DEF),
        .LEN_DIGITS (LEN_DIGITS_DEF),
        .DATA_MAX   (DATA_MAX_DEF),
        .CRC_MAX    (CRC_MAX_DEF)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_ready        (rx_ready),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .cmd_class       (cmd_class),
        .declared_length (declared_length),
        .crc_text        (crc_text),
        .crc_chars       (crc_chars),
        .data_count      (data_count),
        .data_byte       (data_byte),
        .last            (last)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     frame_results_due.size());
            $display("ascii_command_frame_parser: mismatch");
            $finish;
        end
    end

    // result side ready: long hold-off first, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            res_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // compare every accepted result word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (frame_results_due.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                errors++;
            end
            else
            begin
                want = frame_results_due.pop_front();
                check_field("cmd_class", 32'(want.cls), 32'(cmd_class));
                check_field("declared_length", 32'(want.len), 32'(declared_length));
                check_field("crc_text", want.crc, crc_text);
                check_field("crc_chars", 32'(want.crc_n), 32'(crc_chars));
                check_field("data_count", 32'(want.dcount), 32'(data_count));
                check_field("data_byte", 32'(want.dbyte), 32'(data_byte));
                check_field("last", 32'(want.fin), 32'(last));
            end
        end
    end

    task automatic clear_frame();
        field_cnt = 0;
        cmd_len = 0;
        len_val = '0;
        data_len = 0;
        crc_len = 0;
        foreach (cmd_buf[i]) cmd_buf[i] = 8'h00;
        foreach (crc_buf[i]) crc_buf[i] = 8'h00;
    endtask

    // advance the predicted parser by one accepted byte
    task automatic track_byte(input logic [7:0] b);
        frame_result_t r;
        logic [CLASS_W-1:0] cls;
        int n;
        int v;
        if (pstate != PS_IDLE || b == CHAR_START)
            bytes_used++;
        if (b == CHAR_START)
        begin
            pstate = PS_CMD;
            clear_frame();
        end
        else if (b == CHAR_SEP)
        begin
            if (pstate != PS_IDLE && pstate != PS_TAIL)
            begin
                pstate = parse_state_t'(pstate + 1);
                field_cnt = 0;
            end
        end
        else if (b == CHAR_END)
        begin
            // end mark closes the frame but leaves its fields intact
            if (pstate != PS_IDLE)
            begin
                pstate = PS_IDLE;
                frames_closed++;
                cls = CLASS_OTHER;
                if (cmd_len == 4 && cmd_buf[0] == CHAR_H && cmd_buf[1] == CHAR_W)
                begin
                    if (cmd_buf[2] == CHAR_W && cmd_buf[3] == CHAR_R)
                        cls = CLASS_WRITE;
                    else if (cmd_buf[2] == CHAR_R && cmd_buf[3] == CHAR_D)
                        cls = CLASS_READ;
                end
                n = (data_len == 0) ? 1 : data_len;
                for (int k = 0; k < n; k++)
                begin
                    r.cls = cls;
                    r.len = len_val;
                    r.crc = {crc_buf[0], crc_buf[1], crc_buf[2], crc_buf[3]};
                    r.crc_n = CRC_CHARS_W'(crc_len);
                    r.dcount = DATA_COUNT_W'(data_len);
                    r.dbyte = (k < data_len) ? data_buf[k] : 8'h00;
                    r.fin = (k + 1 == n);
                    frame_results_due.push_back(r);
                    results_due++;
                end
            end
        end
        else
        begin
            case (pstate)
                PS_CMD:
                begin
                    if (field_cnt < CMD_MAX_DEF - 1)
                    begin
                        cmd_buf[field_cnt] = b;
                        field_cnt++;
                        cmd_len = field_cnt;
                    end
                end
                PS_LEN:
                begin
                    // non-digits skipped, extra digits dropped
                    if (field_cnt < LEN_DIGITS_DEF && b >= CHAR_ZERO && b <= CHAR_NINE)
                    begin
                        v = int'(len_val) * RADIX + int'(b - CHAR_ZERO);
                        len_val = (v > int'(LEN_SAT)) ? LEN_SAT : LENGTH_W'(v);
                        field_cnt++;
                    end
                end
                PS_DATA:
                begin
                    if (field_cnt < DATA_MAX_DEF - 1)
                    begin
                        data_buf[field_cnt] = b;
                        field_cnt++;
                        data_len = field_cnt;
                    end
                end
                PS_CRC:
                begin
                    if (field_cnt < CRC_MAX_DEF && field_cnt < CRC_SLOTS)
                    begin
                        crc_buf[field_cnt] = b;
                        field_cnt++;
                        crc_len = field_cnt;
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // offer one byte word and wait for it to be taken; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_valid = 1'b0;
            @(negedge clk);
        end
        rx_valid = 1'b1;
        rx_byte = b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        track_byte(b);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // any byte except the three framing marks
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == CHAR_START || c == CHAR_SEP || c == CHAR_END)
            c = c ^ 8'h01;
        return c;
    endfunction

    // one frame: mostly well formed, some cut short, some pure noise
    task automatic send_random_frame();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            return;
        end
        send_byte(CHAR_START);
        case ($urandom_range(3))
            0: send_text("HWWR");
            1: send_text("HWRD");
            // near misses built from the command letters, up to past the limit
            2: repeat ($urandom_range(0, 9)) send_byte(8'("HWRD" >> (8 * $urandom_range(3))));
            default: repeat ($urandom_range(0, 9)) send_byte(plain_char());
        endcase
        if (kind < 22)
        begin
            // closed early, or abandoned for the next start mark
            if (kind < 17)
                send_byte(CHAR_END);
            return;
        end
        send_byte(CHAR_SEP);
        repeat ($urandom_range(0, 5))
            send_byte(($urandom_range(9) == 0) ? plain_char() : CHAR_ZERO + 8'($urandom_range(9)));
        send_byte(CHAR_SEP);
        n = ($urandom_range(9) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 8);
        repeat (n) send_byte(plain_char());
        send_byte(CHAR_SEP);
        repeat ($urandom_range(0, 6)) send_byte(plain_char());
        if ($urandom_range(3) == 0)
        begin
            send_byte(CHAR_SEP);
            repeat ($urandom_range(0, 3)) send_byte(($urandom_range(1) == 1) ? CHAR_SEP : plain_char());
        end
        send_byte(CHAR_END);
        if ($urandom_range(9) == 0)
            send_byte(CHAR_END);
    endtask

    // bytes outside a frame are dropped
    task automatic test_idle_bytes();
        send_byte(8'h00);
        send_byte(CHAR_SEP);
        send_byte(CHAR_END);
    endtask

    // write and read commands, length digits, data extremes, crc overflow, tail commas
    task automatic test_directed_frames();
        send_text("$HWWR,9x99,");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text(",AB12Z@");
        // repeated end mark outside a frame is dropped
        send_byte(CHAR_END);
        send_text("$HWRD,,,,,@");
    endtask

    // random frames under one idle mix, until at least one frame has closed
    task automatic test_random_traffic(input int tx_idle, input int rx_stall);
        int results_start;
        send_idle_pct = tx_idle;
        stall_pct = rx_stall;
        results_start = results_due;
        while (results_due == results_start)
            send_random_frame();
    endtask

    // results held back for a long stretch while the next frame keeps coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        send_text("$HWRD,4,");
        repeat (4) send_byte(plain_char());
        send_text(",C0DE@");
        // second frame waits at the input until the hold-off ends
        send_text("$HWWR,1,Q,9@");
        stall_pct = 20;
    endtask

    initial
    begin
        clear_frame();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_bytes();
        test_directed_frames();
        test_random_traffic(0, 0);
        test_random_traffic(56, 0);
        test_random_traffic(0, 56);
        test_random_traffic(28, 28);
        test_backpressure();

        rx_valid = 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d frames from %0d frame bytes, %0d result words checked",
                 frames_closed, bytes_used, results_seen);
        $display("mixes: free running, input gaps, output stalls, both, long output hold-off");
        if (errors == 0)
            $display("ascii_command_frame_parser: match");
        else
            $display("ascii_command_frame_parser: mismatch");
        $finish;
    end

endmodule
